>>> hw/rtl/word_delta_patch_encoder_defines.svh
// Assertion macros used by the front of the patch encoder.
// Each macro expects signals named clk and rst in the using module.
`ifndef WORD_DELTA_PATCH_ENCODER_DEFINES_SVH
`define WORD_DELTA_PATCH_ENCODER_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define WDPE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("word_delta_patch_encoder: check failed");

// A condition that implies another in the same cycle.
`define WDPE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("word_delta_patch_encoder: check failed");

// A condition that implies another in the following cycle.
`define WDPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("word_delta_patch_encoder: check failed");

`endif

>>> hw/rtl/wdpe_pkg.sv
// Shared types and constants of the word delta patch encoder.
// Used by the front, queue, back and top level; depends on nothing.
`timescale 1ns / 1ps

package wdpe_pkg;

  // Depth of the token queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Input item of one word pair.
  typedef struct packed {
    logic [15:0] earlier_word;
    logic [15:0] later_word;
    logic        last_item;
  } item_t;

  // One word of the patch stream.
  typedef struct packed {
    logic [15:0] patch_word;
    logic        end_of_patch;
  } patch_t;

  // Kinds of work the front hands to the back.
  typedef enum logic [1:0] {
    TOK_LSKIP,
    TOK_HDR,
    TOK_DATA,
    TOK_TERM
  } tok_kind_t;

  // A token expands into one to three patch words.
  typedef struct packed {
    tok_kind_t   kind;
    logic [31:0] data;
  } token_t;

  // Front sequencer states.
  typedef enum logic [2:0] {
    FR_ITEM,
    FR_LSKIP,
    FR_HDR,
    FR_DATA,
    FR_TERM
  } front_state_t;

endpackage

>>> hw/rtl/word_delta_patch_encoder.sv
// A pair's first patch word passes the front sequencer, token queue, token register and output
// register. A pair with no output leaves the front free; else it stalls pairs until its tokens
// are pushed, a flushed run giving a header and one data token per word from the run store port.
// The back emits one patch word per cycle while patch_stall is low and tokens are queued, so long
// records drain while the front runs ahead. Reset clears the skip counter, open run, token queue
// and output register; the run store needs no clearing pass, as only open-run entries are read.
`timescale 1ns / 1ps

module word_delta_patch_encoder #(
  parameter int MAX_RUN = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  wdpe_pkg::item_t   item,
  output logic              patch_valid,
  input  logic              patch_stall,
  output wdpe_pkg::patch_t  patch
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  wdpe_pkg::token_t q_in;
  wdpe_pkg::token_t q_out;

  // Front: pair classification and run store.
  wdpe_front #(
    .MAX_RUN(MAX_RUN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_full     (q_full)
  );

  // Token queue between the two halves.
  wdpe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Back: token expansion and output register.
  wdpe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_pop       (q_pop),
    .q_data      (q_out),
    .q_empty     (q_empty),
    .patch_valid (patch_valid),
    .patch_stall (patch_stall),
    .patch       (patch)
  );

endmodule

>>> hw/rtl/wdpe_fifo.sv
// Small token queue between the front and back of the patch encoder.
// Depends on wdpe_pkg for the token type and depth.
`timescale 1ns / 1ps

module wdpe_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wdpe_pkg::token_t  push_data,
  output logic              full,
  input  logic              pop,
  output wdpe_pkg::token_t  pop_data,
  output logic              empty
);

  wdpe_pkg::token_t                  slots [wdpe_pkg::QUEUE_DEPTH];
  logic [wdpe_pkg::QUEUE_AW-1:0]     wr_ptr;
  logic [wdpe_pkg::QUEUE_AW-1:0]     rd_ptr;
  logic [wdpe_pkg::QUEUE_AW:0]       count;
  logic                              do_push;
  logic                              do_pop;

  assign full     = count == (wdpe_pkg::QUEUE_AW + 1)'(wdpe_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> hw/rtl/wdpe_front.sv
// Front of the patch encoder: accepts word pairs, tracks skips and runs,
// holds the open run and queues tokens. Depends on wdpe_pkg and the macros.
`timescale 1ns / 1ps
`include "word_delta_patch_encoder_defines.svh"

module wdpe_front #(
  parameter int MAX_RUN = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  wdpe_pkg::item_t   item,
  output logic              q_push,
  output wdpe_pkg::token_t  q_data,
  input  logic              q_full
);

  localparam int LEN_W = $clog2(MAX_RUN + 1);
  localparam int IDX_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  wdpe_pkg::front_state_t state;
  wdpe_pkg::front_state_t state_next;

  logic [31:0]      skip_count;
  logic [31:0]      skip_count_next;
  logic [15:0]      run_skip;
  logic [15:0]      run_skip_next;
  logic [LEN_W-1:0] run_length;
  logic [LEN_W-1:0] run_length_next;

  logic             pend_flush;
  logic             pend_term;
  logic [31:0]      lskip_val;
  logic [31:0]      lskip_val_next;
  logic [LEN_W-1:0] flush_len;
  logic [LEN_W-1:0] flush_len_next;
  logic [15:0]      flush_skip;
  logic [15:0]      flush_skip_next;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] ptr_next;

  logic             item_fire;
  logic             lskip_now;
  logic             flush_now;
  logic             term_now;
  logic             wr_en;
  logic [LEN_W-1:0] run_len_inc;
  logic [15:0]      run_skip_eff;
  logic             data_last;

  logic [15:0]      run_store [MAX_RUN];
  logic [IDX_W-1:0] rd_addr;
  logic [15:0]      rd_data;

  assign item_fire   = item_valid && (state == wdpe_pkg::FR_ITEM);
  assign item_stall  = state != wdpe_pkg::FR_ITEM;
  assign run_len_inc = run_length + 1'b1;
  assign data_last   = LEN_W'(ptr) == flush_len - 1'b1;

  // Classify the accepted pair and work out the new skip and run state.
  always_comb begin
    skip_count_next = skip_count;
    run_skip_next   = run_skip;
    run_length_next = run_length;
    lskip_val_next  = lskip_val;
    flush_len_next  = flush_len;
    flush_skip_next = flush_skip;
    lskip_now       = 1'b0;
    flush_now       = 1'b0;
    term_now        = 1'b0;
    wr_en           = 1'b0;
    run_skip_eff    = run_skip;
    if (item_fire) begin
      if (item.earlier_word != item.later_word) begin
        // A changed word opens or extends a run.
        if (run_length == '0) begin
          if (skip_count > 32'h0000_ffff) begin
            lskip_now      = 1'b1;
            lskip_val_next = skip_count;
            run_skip_eff   = 16'h0000;
          end else begin
            run_skip_eff = skip_count[15:0];
          end
          skip_count_next = '0;
        end
        wr_en = 1'b1;
        if (run_len_inc == LEN_W'(MAX_RUN) || item.last_item) begin
          flush_now       = 1'b1;
          flush_len_next  = run_len_inc;
          flush_skip_next = run_skip_eff;
          run_length_next = '0;
          run_skip_next   = '0;
        end else begin
          run_length_next = run_len_inc;
          run_skip_next   = run_skip_eff;
        end
      end else begin
        // An equal word closes any open run and counts as skipped.
        if (run_length != '0) begin
          flush_now       = 1'b1;
          flush_len_next  = run_length;
          flush_skip_next = run_skip;
          run_length_next = '0;
          run_skip_next   = '0;
          skip_count_next = 32'd1;
        end else if (skip_count == 32'hffff_ffff) begin
          lskip_now       = 1'b1;
          lskip_val_next  = skip_count;
          skip_count_next = 32'd1;
        end else begin
          skip_count_next = skip_count + 32'd1;
        end
      end
      // The final pair ends the snapshot and clears all counting.
      if (item.last_item) begin
        term_now        = 1'b1;
        skip_count_next = '0;
        run_skip_next   = '0;
        run_length_next = '0;
      end
    end
  end

  // Sequencer that pushes the tokens of one item in patch order.
  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    q_push     = (state != wdpe_pkg::FR_ITEM) && !q_full;
    q_data     = '{kind: wdpe_pkg::TOK_TERM, data: 32'h0};
    rd_addr    = '0;
    case (state)
      wdpe_pkg::FR_ITEM: begin
        ptr_next = '0;
        if (item_fire) begin
          if (lskip_now) begin
            state_next = wdpe_pkg::FR_LSKIP;
          end else if (flush_now) begin
            state_next = wdpe_pkg::FR_HDR;
          end else if (term_now) begin
            state_next = wdpe_pkg::FR_TERM;
          end
        end
      end
      wdpe_pkg::FR_LSKIP: begin
        q_data = '{kind: wdpe_pkg::TOK_LSKIP, data: lskip_val};
        if (!q_full) begin
          if (pend_flush) begin
            state_next = wdpe_pkg::FR_HDR;
          end else if (pend_term) begin
            state_next = wdpe_pkg::FR_TERM;
          end else begin
            state_next = wdpe_pkg::FR_ITEM;
          end
        end
      end
      wdpe_pkg::FR_HDR: begin
        q_data = '{kind: wdpe_pkg::TOK_HDR,
                   data: {flush_skip, {(16 - LEN_W){1'b0}}, flush_len}};
        if (!q_full) begin
          state_next = wdpe_pkg::FR_DATA;
        end
      end
      wdpe_pkg::FR_DATA: begin
        q_data  = '{kind: wdpe_pkg::TOK_DATA, data: {16'h0000, rd_data}};
        rd_addr = ptr;
        if (!q_full) begin
          if (data_last) begin
            ptr_next = '0;
            rd_addr  = '0;
            if (pend_term) begin
              state_next = wdpe_pkg::FR_TERM;
            end else begin
              state_next = wdpe_pkg::FR_ITEM;
            end
          end else begin
            ptr_next = ptr + 1'b1;
            rd_addr  = ptr + 1'b1;
          end
        end
      end
      wdpe_pkg::FR_TERM: begin
        q_data = '{kind: wdpe_pkg::TOK_TERM, data: 32'h0};
        if (!q_full) begin
          state_next = wdpe_pkg::FR_ITEM;
        end
      end
      default: begin
        state_next = wdpe_pkg::FR_ITEM;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wdpe_pkg::FR_ITEM;
      skip_count <= '0;
      run_skip   <= '0;
      run_length <= '0;
      pend_flush <= 1'b0;
      pend_term  <= 1'b0;
      ptr        <= '0;
    end else begin
      state      <= state_next;
      skip_count <= skip_count_next;
      run_skip   <= run_skip_next;
      run_length <= run_length_next;
      ptr        <= ptr_next;
      if (item_fire) begin
        pend_flush <= flush_now;
        pend_term  <= term_now;
      end
    end
  end

  // Values carried from the accepting cycle to the token pushes.
  always_ff @(posedge clk) begin
    lskip_val  <= lskip_val_next;
    flush_len  <= flush_len_next;
    flush_skip <= flush_skip_next;
  end

  // Run store: written on each changed word, read one entry per cycle
  // during a flush while the queue is not full. The header cycle always primes entry zero.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      run_store[run_length[IDX_W-1:0]] <= item.earlier_word;
    end
    rd_data <= run_store[rd_addr];
  end

  `WDPE_ASSERT(a_run_below_cap, run_length < LEN_W'(MAX_RUN))
  `WDPE_ASSERT_NEXT(a_last_clears, item_fire && item.last_item,
                    run_length == '0 && skip_count == '0 && run_skip == '0)
  `WDPE_ASSERT_IMPL(a_data_in_run, state == wdpe_pkg::FR_DATA,
                    flush_len != '0 && LEN_W'(ptr) < flush_len)

endmodule

>>> hw/rtl/wdpe_back.sv
// Back of the patch encoder: expands queued tokens into patch words and
// holds them in the output register. Depends on wdpe_pkg.
`timescale 1ns / 1ps

module wdpe_back (
  input  logic              clk,
  input  logic              rst,
  output logic              q_pop,
  input  wdpe_pkg::token_t  q_data,
  input  logic              q_empty,
  output logic              patch_valid,
  input  logic              patch_stall,
  output wdpe_pkg::patch_t  patch
);

  wdpe_pkg::token_t tok;
  logic             tok_valid;
  logic [1:0]       phase;
  logic [15:0]      word;
  logic             word_end;
  logic             last_phase;
  logic             out_load;

  // Word of the current token at the current phase.
  always_comb begin
    word       = 16'h0000;
    word_end   = 1'b0;
    last_phase = 1'b1;
    case (tok.kind)
      wdpe_pkg::TOK_LSKIP: begin
        last_phase = phase == 2'd2;
        if (phase == 2'd1) begin
          word = tok.data[15:0];
        end else if (phase == 2'd2) begin
          word = tok.data[31:16];
        end
      end
      wdpe_pkg::TOK_HDR: begin
        last_phase = phase == 2'd1;
        word       = (phase == 2'd0) ? tok.data[15:0] : tok.data[31:16];
      end
      wdpe_pkg::TOK_DATA: begin
        word = tok.data[15:0];
      end
      wdpe_pkg::TOK_TERM: begin
        last_phase = phase == 2'd2;
        word_end   = phase == 2'd2;
      end
      default: begin
        last_phase = 1'b1;
      end
    endcase
  end

  assign out_load = tok_valid && (!patch_valid || !patch_stall);
  assign q_pop    = !q_empty && (!tok_valid || (out_load && last_phase));

  // Token register and phase counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      phase     <= 2'd0;
    end else if (q_pop) begin
      tok_valid <= 1'b1;
      phase     <= 2'd0;
    end else if (out_load) begin
      if (last_phase) begin
        tok_valid <= 1'b0;
        phase     <= 2'd0;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tok <= q_data;
    end
  end

  // Output register; a word stays until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      patch_valid <= 1'b0;
    end else if (out_load) begin
      patch_valid <= 1'b1;
    end else if (!patch_stall) begin
      patch_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      patch.patch_word   <= word;
      patch.end_of_patch <= word_end;
    end
  end

endmodule
